// File: src/htfc_pkg.sv
// shared types, constants and functions of the humidity and temperature frame checker
package htfc_pkg;

	// frame layout and crc
	typedef logic [2:0] pos_t;
	localparam pos_t POS_TEMP_HI  = 3'd0;
	localparam pos_t POS_TEMP_LO  = 3'd1;
	localparam pos_t POS_TEMP_CRC = 3'd2;
	localparam pos_t POS_HUM_HI   = 3'd3;
	localparam pos_t POS_HUM_LO   = 3'd4;
	localparam pos_t POS_HUM_CRC  = 3'd5;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// scaling
	localparam int TPROD_W = 27;
	localparam int HPROD_W = 23;
	localparam int TQ_W    = 11;
	localparam int HQ_W    = 7;
	localparam logic [10:0] TEMP_SCALE  = 11'd1750;
	localparam logic [6:0]  HUM_SCALE   = 7'd100;
	localparam logic [10:0] TEMP_OFFSET = 11'd450;
	localparam logic [16:0] DIV_K       = 17'd65535;

	// assembled frame passed to the scaling stages
	typedef struct packed {
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
		logic        temp_crc_ok;
		logic        hum_crc_ok;
	} frame_t;

	// quotient by 65535 with a nonzero-remainder flag
	typedef struct packed {
		logic [TQ_W-1:0] q;
		logic            rem_nz;
	} quot_t;

	// crc-8, polynomial 0x31, msb first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

	// x / 65535 for x below 2^27: x = q0*65535 + (q0 + lo), one correction step
	function automatic quot_t div65535(input logic [TPROD_W-1:0] x);
		logic [TQ_W-1:0] q0;
		logic [16:0]     r0;
		logic            ge;
		quot_t           res;
		q0 = x[TPROD_W-1:16];
		r0 = {1'b0, x[15:0]} + {6'd0, q0};
		ge = (r0 >= DIV_K);
		res.q = q0 + {{(TQ_W-1){1'b0}}, ge};
		res.rem_nz = ge ? (r0 != DIV_K) : (r0 != 17'd0);
		return res;
	endfunction

endpackage

// File: src/htfc_in_if.sv
// byte request channel: start marker and received byte
interface htfc_in_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [7:0] rx_byte;

	modport source (output valid, output start_req, output rx_byte, input ready);
	modport sink (input valid, input start_req, input rx_byte, output ready);
endinterface

// File: src/htfc_out_if.sv
// result request channel: raw words, crc flags and scaled values
interface htfc_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        temp_raw;
	logic [15:0]        hum_raw;
	logic               temp_crc_ok;
	logic               hum_crc_ok;
	logic signed [11:0] temp_deci;
	logic [6:0]         hum_pct;

	modport source (output valid, output temp_raw, output hum_raw, output temp_crc_ok,
		output hum_crc_ok, output temp_deci, output hum_pct, input ready);
	modport sink (input valid, input temp_raw, input hum_raw, input temp_crc_ok,
		input hum_crc_ok, input temp_deci, input hum_pct, output ready);
endinterface

// File: src/htfc_frame.sv
// frame assembly: byte position, running crc and the completed-frame register
module htfc_frame import htfc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	htfc_in_if.sink rx,
	output logic   frame_vld,
	output frame_t frame,
	input  logic   frame_rdy
);

	logic        vld_s1;
	frame_t      frame_s1;
	pos_t        pos_q;
	logic [7:0]  crc_q;
	logic        temp_ok_q;
	logic [15:0] temp_word_q;
	logic [7:0]  hum_hi_q;
	logic [7:0]  hum_lo_q;

	logic        acc;
	pos_t        pos;
	logic [7:0]  crc_base;
	logic [7:0]  crc_next;
	logic        done;

	// accept while the frame register is free or draining
	assign rx.ready = !vld_s1 || frame_rdy;
	assign acc      = rx.valid && rx.ready;

	// start marker restarts the frame
	assign pos      = rx.start_req ? POS_TEMP_HI : pos_q;
	assign crc_base = rx.start_req ? CRC_INIT : crc_q;
	assign crc_next = crc8_update(crc_base, rx.rx_byte);
	assign done     = (pos == POS_HUM_CRC);

	// position, crc and crc flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_TEMP_HI;
			crc_q     <= CRC_INIT;
			temp_ok_q <= 1'b0;
		end else if (acc) begin
			case (pos)
				POS_TEMP_LO, POS_HUM_HI, POS_HUM_LO: begin
					crc_q <= crc_next;
					pos_q <= pos + 3'd1;
				end
				POS_TEMP_CRC: begin
					temp_ok_q <= (crc_base == rx.rx_byte);
					crc_q     <= CRC_INIT;
					pos_q     <= POS_HUM_HI;
				end
				POS_HUM_CRC: begin
					crc_q <= CRC_INIT;
					pos_q <= POS_TEMP_HI;
				end
				default: begin
					// first byte, also taken for unused positions
					crc_q <= crc_next;
					pos_q <= POS_TEMP_LO;
				end
			endcase
		end
	end

	// collected data bytes
	always_ff @(posedge clk) begin
		if (acc) begin
			case (pos)
				POS_TEMP_LO:  temp_word_q[7:0] <= rx.rx_byte;
				POS_HUM_HI:   hum_hi_q         <= rx.rx_byte;
				POS_HUM_LO:   hum_lo_q         <= rx.rx_byte;
				POS_TEMP_CRC, POS_HUM_CRC: ;
				default:      temp_word_q      <= {rx.rx_byte, 8'd0};
			endcase
		end
	end

	// completed frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc && done) begin
			vld_s1 <= 1'b1;
		end else if (frame_rdy) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && done) begin
			frame_s1.temp_raw    <= temp_word_q;
			frame_s1.hum_raw     <= {hum_hi_q, hum_lo_q};
			frame_s1.temp_crc_ok <= temp_ok_q;
			frame_s1.hum_crc_ok  <= (crc_base == rx.rx_byte);
		end
	end

	assign frame_vld = vld_s1;
	assign frame     = frame_s1;

endmodule

// File: src/htfc_scale.sv
// scaling: constant multiply, then division by 65535 into the result register
module htfc_scale import htfc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   frame_vld,
	input  frame_t frame,
	output logic   frame_rdy,
	htfc_out_if.source result
);

	logic               vld_s2;
	frame_t             frame_s2;
	logic [TPROD_W-1:0] tprod_s2;
	logic [HPROD_W-1:0] hprod_s2;

	logic               vld_s3;
	frame_t             frame_s3;
	logic signed [11:0] temp_deci_s3;
	logic [HQ_W-1:0]    hum_pct_s3;

	logic               rdy_s3;
	logic               rdy_s2;
	quot_t              tq;
	quot_t              hq;
	logic [TQ_W-1:0]    tq_adj;
	logic signed [11:0] temp_deci;

	// stage handshake
	assign rdy_s3    = !vld_s3 || result.ready;
	assign rdy_s2    = !vld_s2 || rdy_s3;
	assign frame_rdy = rdy_s2;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= frame_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && frame_vld) begin
			frame_s2 <= frame;
			tprod_s2 <= {{(TPROD_W-16){1'b0}}, frame.temp_raw} *
				{{(TPROD_W-11){1'b0}}, TEMP_SCALE};
			hprod_s2 <= {{(HPROD_W-16){1'b0}}, frame.hum_raw} *
				{{(HPROD_W-7){1'b0}}, HUM_SCALE};
		end
	end

	// divide by 65535; below the offset round the quotient up for truncation toward zero
	assign tq        = div65535(tprod_s2);
	assign hq        = div65535({{(TPROD_W-HPROD_W){1'b0}}, hprod_s2});
	assign tq_adj    = tq.q + {{(TQ_W-1){1'b0}}, ((tq.q < TEMP_OFFSET) && tq.rem_nz)};
	assign temp_deci = $signed({1'b0, tq_adj}) - $signed({1'b0, TEMP_OFFSET});

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			frame_s3     <= frame_s2;
			temp_deci_s3 <= temp_deci;
			hum_pct_s3   <= hq.q[HQ_W-1:0];
		end
	end

	assign result.valid       = vld_s3;
	assign result.temp_raw    = frame_s3.temp_raw;
	assign result.hum_raw     = frame_s3.hum_raw;
	assign result.temp_crc_ok = frame_s3.temp_crc_ok;
	assign result.hum_crc_ok  = frame_s3.hum_crc_ok;
	assign result.temp_deci   = temp_deci_s3;
	assign result.hum_pct     = hum_pct_s3;

endmodule

// File: src/humidity_temp_frame_checker.sv
// Humidity and temperature sensor frame checker, top level.
// Throughput: one byte per cycle while result.ready does not hold the pipeline; back-to-back frames run at full rate.
// After the sixth byte is accepted, the frame passes through the frame register and the
// multiply stage, then the divide stage into the result register.
// Reset clears byte position, crc, crc flag and all stage valid bits; data
// registers are not reset.
module humidity_temp_frame_checker import htfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	htfc_in_if.sink rx,
	htfc_out_if.source result
);

	logic   frame_vld;
	logic   frame_rdy;
	frame_t frame;

	// byte collection and crc checks
	htfc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.frame_vld (frame_vld),
		.frame     (frame),
		.frame_rdy (frame_rdy)
	);

	// temperature and humidity scaling
	htfc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_vld (frame_vld),
		.frame     (frame),
		.frame_rdy (frame_rdy),
		.result    (result)
	);

endmodule
